// ===== design/prg_pkg.sv =====
package prg_pkg;

	// Field and register widths
	localparam int XY_W      = 12;
	localparam int JIT_W     = 16;
	localparam int COMP_W    = 16;
	localparam int NCOMP     = 3;
	localparam int VEC_W     = NCOMP * COMP_W;
	localparam int RATIO_W   = 16;
	localparam int INV_W     = 24;
	localparam int CFG_W     = VEC_W;
	localparam int CFG_IDX_W = 3;
	localparam int DIR_W     = 16;

	// Screen-space arithmetic
	localparam int PW_W    = RATIO_W + INV_W;   // pixel pitch, Q36
	localparam int YH_W    = XY_W + INV_W;
	localparam int VH_W    = JIT_W + INV_W;
	localparam int XP_W    = XY_W + PW_W;
	localparam int UP_W    = JIT_W + PW_W;
	localparam int FRAC_SH = 15;                // random fraction times reciprocal size, doubled
	localparam int Q24_SH  = 24;
	localparam int SY24_W  = 39;
	localparam int SX36_W  = 55;
	localparam int SX_SH   = 16;
	localparam int SY_SH   = 4;
	localparam int SX_W    = SX36_W - SX_SH;
	localparam int SY_W    = SY24_W - SY_SH;
	localparam longint ONE_Q24 = 64'd1 << Q24_SH;
	localparam longint SX_HALF = 64'd1 << (SX_SH - 1);
	localparam longint SY_HALF = 64'd1 << (SY_SH - 1);

	// Image-plane vector, Q34
	localparam int RS_W   = COMP_W + SX_W;
	localparam int US_W   = COMP_W + SY_W;
	localparam int D_W    = 56;
	localparam int FWD_SH = 21;

	// Normalization
	localparam int MAG_W = D_W;
	localparam int GRP_W = 8;
	localparam int GRP_N = MAG_W / GRP_W;
	localparam int POS_W = 3;
	localparam int LZ_W  = 6;
	localparam int NRM_W = 30;
	localparam int SQ_W  = 2 * NRM_W;
	localparam int SUM_W = SQ_W + 2;

	// Square root and divide
	localparam int SQ_STEPS  = SUM_W / 2;
	localparam int LEN_W     = SQ_STEPS;
	localparam int DIR_FRAC  = 14;
	localparam int NUM_W     = NRM_W + DIR_FRAC + 2;
	localparam int Q_W       = 15;
	localparam int DIV_STEPS = Q_W;
	localparam int DIR_ONE   = 1 << DIR_FRAC;

	// Reset values
	localparam logic [VEC_W-1:0]   RST_FWD   = 48'h0000_0000_4000;
	localparam logic [VEC_W-1:0]   RST_RIGHT = 48'h0000_4000_0000;
	localparam logic [VEC_W-1:0]   RST_UP    = 48'h4000_0000_0000;
	localparam logic [RATIO_W-1:0] RST_RATIO = 16'h1000;
	localparam logic [INV_W-1:0]   RST_INV   = 24'h004000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CAM_POS = 3'd0,
		REG_FWD     = 3'd1,
		REG_RIGHT   = 3'd2,
		REG_UP      = 3'd3,
		REG_RATIO   = 3'd4,
		REG_INV_W   = 3'd5,
		REG_INV_H   = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [VEC_W-1:0]   fwd;
		logic [VEC_W-1:0]   right;
		logic [VEC_W-1:0]   up;
		logic [RATIO_W-1:0] ratio;
		logic [INV_W-1:0]   inv_w;
		logic [INV_W-1:0]   inv_h;
	} cam_cfg_t;

	typedef logic signed [D_W-1:0] dvec_t [NCOMP];

	// Normalized magnitudes with signs, carried to the divider
	typedef struct packed {
		logic                         zero;
		logic [NCOMP-1:0]             neg;
		logic [NCOMP-1:0][NRM_W-1:0]  n;
	} nrm_t;

	function automatic logic signed [COMP_W-1:0] comp(input logic [VEC_W-1:0] v,
			input int idx);
		return v[idx*COMP_W +: COMP_W];
	endfunction

endpackage

// ===== design/prg_setup.sv =====
module prg_setup import prg_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_vld,
	input  logic [XY_W-1:0]  px,
	input  logic [XY_W-1:0]  py,
	input  logic             jit,
	input  logic [JIT_W-1:0] ju,
	input  logic [JIT_W-1:0] jv,
	input  cam_cfg_t         cfg,
	output logic             out_vld,
	output dvec_t            d
);

	logic vld_s1, vld_s2, vld_s3, vld_s4;

	logic [PW_W-1:0]  pw_s1;
	logic [YH_W-1:0]  yh_s1;
	logic [VH_W-1:0]  vh_s1;
	logic [XY_W-1:0]  x_s1;
	logic [JIT_W-1:0] u_s1;
	logic             jit_s1;

	logic [XP_W-1:0]          xp_s2;
	logic [UP_W-1:0]          up_s2;
	logic [PW_W-1:0]          pw_s2;
	logic signed [SY24_W-1:0] sy24_s2;
	logic                     jit_s2;

	logic signed [SX_W-1:0] sx_s3;
	logic signed [SY_W-1:0] sy_s3;

	logic signed [RS_W-1:0] rs_s4 [NCOMP];
	logic signed [US_W-1:0] us_s4 [NCOMP];

	logic signed [SY24_W-1:0] jy, sy24, syr;
	logic signed [SX36_W-1:0] jx, sx36, sxr;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			out_vld <= 1'b0;
		end else if (en) begin
			vld_s1  <= in_vld;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			out_vld <= vld_s4;
		end
	end

	// stage 1: pixel pitch and y products
	always_ff @(posedge clk) begin
		if (en) begin
			pw_s1  <= PW_W'(cfg.ratio) * PW_W'(cfg.inv_w);
			yh_s1  <= YH_W'(py) * YH_W'(cfg.inv_h);
			vh_s1  <= VH_W'(jv) * VH_W'(cfg.inv_h);
			x_s1   <= px;
			u_s1   <= ju;
			jit_s1 <= jit;
		end
	end

	// stage 2: x products, vertical screen coordinate in Q24
	always_comb begin
		jy = jit_s1 ? SY24_W'({1'b0, vh_s1[VH_W-1:FRAC_SH]}) - SY24_W'({1'b0, cfg.inv_h})
		            : '0;
		sy24 = SY24_W'(ONE_Q24) - SY24_W'({yh_s1, 1'b0}) - jy;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xp_s2   <= XP_W'(x_s1) * XP_W'(pw_s1);
			up_s2   <= UP_W'(u_s1) * UP_W'(pw_s1);
			pw_s2   <= pw_s1;
			sy24_s2 <= sy24;
			jit_s2  <= jit_s1;
		end
	end

	// stage 3: horizontal coordinate, both rounded to Q20
	always_comb begin
		jx = jit_s2 ? SX36_W'({1'b0, up_s2[UP_W-1:FRAC_SH]}) - SX36_W'({1'b0, pw_s2})
		            : '0;
		sx36 = SX36_W'({xp_s2, 1'b0}) - (SX36_W'(cfg.ratio) << Q24_SH) + jx;
		sxr  = sx36 + SX36_W'(SX_HALF);
		syr  = sy24_s2 + SY24_W'(SY_HALF);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s3 <= sxr[SX36_W-1:SX_SH];
			sy_s3 <= syr[SY24_W-1:SY_SH];
		end
	end

	// stage 4: basis products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < NCOMP; c++) begin
				rs_s4[c] <= RS_W'(comp(cfg.right, c)) * RS_W'(sx_s3);
				us_s4[c] <= US_W'(comp(cfg.up, c)) * US_W'(sy_s3);
			end
		end
	end

	// stage 5: image-plane vector
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < NCOMP; c++) begin
				d[c] <= (D_W'(comp(cfg.fwd, c)) <<< FWD_SH) + D_W'(rs_s4[c]) + D_W'(us_s4[c]);
			end
		end
	end

endmodule

// ===== design/prg_norm.sv =====
module prg_norm import prg_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_vld,
	input  dvec_t            d,
	output logic             out_vld,
	output logic [SUM_W-1:0] sum,
	output nrm_t             nrm
);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	logic [MAG_W-1:0] mag_s1 [NCOMP];
	logic [MAG_W-1:0] mag_s2 [NCOMP];
	logic [MAG_W-1:0] mag_s3 [NCOMP];
	logic [MAG_W-1:0] mag_s4 [NCOMP];
	logic [NCOMP-1:0] neg_s1, neg_s2, neg_s3, neg_s4;
	logic [MAG_W-1:0] m_s2;
	logic [GRP_N-1:0] nz_s3;
	logic [POS_W-1:0] pos_s3 [GRP_N];
	logic [LZ_W-1:0]  lz_s4;
	logic             zero_s4;
	nrm_t             nrm_s5, nrm_s6;
	logic [SQ_W-1:0]  sq_s6 [NCOMP];

	logic [MAG_W-1:0] m01, m_max;
	logic [GRP_N-1:0] gnz;
	logic [POS_W-1:0] gpos [GRP_N];
	logic [LZ_W-1:0]  lz;
	logic [MAG_W-1:0] sh [NCOMP];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			out_vld <= 1'b0;
		end else if (en) begin
			vld_s1  <= in_vld;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			out_vld <= vld_s6;
		end
	end

	// stage 1: magnitudes and signs
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < NCOMP; c++) begin
				mag_s1[c] <= d[c][D_W-1] ? MAG_W'(-d[c]) : MAG_W'(d[c]);
				neg_s1[c] <= d[c][D_W-1];
			end
		end
	end

	// stage 2: largest magnitude
	always_comb begin
		m01   = (mag_s1[0] > mag_s1[1]) ? mag_s1[0] : mag_s1[1];
		m_max = (m01 > mag_s1[2]) ? m01 : mag_s1[2];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s2   <= m_max;
			mag_s2 <= mag_s1;
			neg_s2 <= neg_s1;
		end
	end

	// stage 3: leading one within each byte
	always_comb begin
		for (int g = 0; g < GRP_N; g++) begin
			gnz[g]  = |m_s2[g*GRP_W +: GRP_W];
			gpos[g] = '0;
			for (int b = 0; b < GRP_W; b++) begin
				if (m_s2[g*GRP_W + b]) gpos[g] = POS_W'(b);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nz_s3  <= gnz;
			pos_s3 <= gpos;
			mag_s3 <= mag_s2;
			neg_s3 <= neg_s2;
		end
	end

	// stage 4: shift count from the top nonzero byte
	always_comb begin
		lz = '0;
		for (int g = 0; g < GRP_N; g++) begin
			if (nz_s3[g]) lz = LZ_W'(MAG_W - 1 - g*GRP_W) - LZ_W'(pos_s3[g]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lz_s4   <= lz;
			zero_s4 <= ~|nz_s3;
			mag_s4  <= mag_s3;
			neg_s4  <= neg_s3;
		end
	end

	// stage 5: common shift, largest lands in [2^29, 2^30)
	always_comb begin
		for (int c = 0; c < NCOMP; c++) sh[c] = mag_s4[c] << lz_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nrm_s5.zero <= zero_s4;
			nrm_s5.neg  <= neg_s4;
			for (int c = 0; c < NCOMP; c++) nrm_s5.n[c] <= sh[c][MAG_W-1 -: NRM_W];
		end
	end

	// stage 6: squares
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < NCOMP; c++) sq_s6[c] <= SQ_W'(nrm_s5.n[c]) * SQ_W'(nrm_s5.n[c]);
			nrm_s6 <= nrm_s5;
		end
	end

	// stage 7: sum of squares
	always_ff @(posedge clk) begin
		if (en) begin
			sum <= SUM_W'(sq_s6[0]) + SUM_W'(sq_s6[1]) + SUM_W'(sq_s6[2]);
			nrm <= nrm_s6;
		end
	end

endmodule

// ===== design/prg_sqrt.sv =====
module prg_sqrt import prg_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_vld,
	input  logic [SUM_W-1:0] sum,
	input  nrm_t             nrm_i,
	output logic             out_vld,
	output logic [LEN_W-1:0] len,
	output nrm_t             nrm_o
);

	logic [SUM_W-1:0] rem_s  [SQ_STEPS];
	logic [SUM_W-1:0] root_s [SQ_STEPS];
	nrm_t             car_s  [SQ_STEPS];
	logic             vld_s  [SQ_STEPS];

	// one root bit per stage, restoring
	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
		localparam int BP = 2 * (SQ_STEPS - 1 - k);
		logic [SUM_W-1:0] rem_c, root_c, trial;
		logic [SUM_W:0]   diff;
		logic             vld_c;
		nrm_t             car_c;

		if (k == 0) begin : g_first
			assign rem_c  = sum;
			assign root_c = '0;
			assign vld_c  = in_vld;
			assign car_c  = nrm_i;
		end else begin : g_next
			assign rem_c  = rem_s[k-1];
			assign root_c = root_s[k-1];
			assign vld_c  = vld_s[k-1];
			assign car_c  = car_s[k-1];
		end

		assign trial = root_c + (SUM_W'(1) << BP);
		assign diff  = {1'b0, rem_c} - {1'b0, trial};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_c;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!diff[SUM_W]) begin
					rem_s[k]  <= diff[SUM_W-1:0];
					root_s[k] <= (root_c >> 1) + (SUM_W'(1) << BP);
				end else begin
					rem_s[k]  <= rem_c;
					root_s[k] <= root_c >> 1;
				end
				car_s[k] <= car_c;
			end
		end
	end

	assign out_vld = vld_s[SQ_STEPS-1];
	assign len     = root_s[SQ_STEPS-1][LEN_W-1:0];
	assign nrm_o   = car_s[SQ_STEPS-1];

endmodule

// ===== design/prg_div.sv =====
module prg_div import prg_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_vld,
	input  logic [LEN_W-1:0]        len,
	input  nrm_t                    nrm,
	output logic                    out_vld,
	output logic signed [DIR_W-1:0] dir_x,
	output logic signed [DIR_W-1:0] dir_y,
	output logic signed [DIR_W-1:0] dir_z
);

	typedef logic [NCOMP-1:0][NUM_W-1:0] num_vec_t;
	typedef logic [NCOMP-1:0][Q_W-1:0]   q_vec_t;

	logic             vld_s0;
	num_vec_t         num_s0;
	logic [LEN_W-1:0] len_s0;
	logic             zero_s0;
	logic [NCOMP-1:0] neg_s0;

	num_vec_t         rem_s  [DIV_STEPS];
	q_vec_t           q_s    [DIV_STEPS];
	logic [LEN_W-1:0] len_s  [DIV_STEPS];
	logic             zero_s [DIV_STEPS];
	logic [NCOMP-1:0] neg_s  [DIV_STEPS];
	logic             vld_s  [DIV_STEPS];

	logic signed [DIR_W-1:0] dv [NCOMP];

	// stage 0: scaled numerators with rounding half
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else if (en) begin
			vld_s0 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < NCOMP; c++) begin
				num_s0[c] <= (NUM_W'(nrm.n[c]) << DIR_FRAC) + NUM_W'(len >> 1);
			end
			len_s0  <= len;
			zero_s0 <= nrm.zero;
			neg_s0  <= nrm.neg;
		end
	end

	// one quotient bit per stage, three lanes
	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
		localparam int BP = DIV_STEPS - 1 - j;
		num_vec_t         rem_c, rem_n;
		q_vec_t           q_c, q_n;
		logic [LEN_W-1:0] len_c;
		logic             zero_c, vld_c;
		logic [NCOMP-1:0] neg_c;
		logic [NUM_W-1:0] dsh;
		logic [NUM_W:0]   diff [NCOMP];

		if (j == 0) begin : g_first
			assign rem_c  = num_s0;
			assign q_c    = '0;
			assign len_c  = len_s0;
			assign zero_c = zero_s0;
			assign neg_c  = neg_s0;
			assign vld_c  = vld_s0;
		end else begin : g_next
			assign rem_c  = rem_s[j-1];
			assign q_c    = q_s[j-1];
			assign len_c  = len_s[j-1];
			assign zero_c = zero_s[j-1];
			assign neg_c  = neg_s[j-1];
			assign vld_c  = vld_s[j-1];
		end

		assign dsh = NUM_W'(len_c) << BP;

		always_comb begin
			rem_n = rem_c;
			q_n   = q_c;
			for (int c = 0; c < NCOMP; c++) begin
				diff[c] = {1'b0, rem_c[c]} - {1'b0, dsh};
				if (!diff[c][NUM_W]) begin
					rem_n[c]    = diff[c][NUM_W-1:0];
					q_n[c][BP]  = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en) begin
				vld_s[j] <= vld_c;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j]  <= rem_n;
				q_s[j]    <= q_n;
				len_s[j]  <= len_c;
				zero_s[j] <= zero_c;
				neg_s[j]  <= neg_c;
			end
		end
	end

	// output register: sign applied, zero vector gives zero
	always_comb begin
		for (int c = 0; c < NCOMP; c++) begin
			if (zero_s[DIV_STEPS-1]) begin
				dv[c] = '0;
			end else if (neg_s[DIV_STEPS-1][c]) begin
				dv[c] = -DIR_W'(q_s[DIV_STEPS-1][c]);
			end else begin
				dv[c] = DIR_W'(q_s[DIV_STEPS-1][c]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (en) begin
			out_vld <= vld_s[DIV_STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dir_x <= dv[0];
			dir_y <= dv[1];
			dir_z <= dv[2];
		end
	end

endmodule

// ===== design/pinhole_camera_ray_generator.sv =====
// Pinhole camera primary ray direction generator. Each item is a pixel coordinate with
// optional sub-pixel jitter; the result is the unit view ray through that pixel as three
// signed Q1.14 components. One item is taken every clock while the output is not stalled.
// 5 stages form the image-plane vector, 7 scale it and sum its squares, 31 stages resolve
// the square root one bit each, and 17 form the scaled numerators, run the three dividers
// one quotient bit per stage and drive the output register. A stall at the output holds
// the whole pipeline. The user must write basis vectors, aspect ratio and the reciprocal
// image sizes through the config port only while no item is in flight; the block does not
// enforce this. The camera position is accepted there but does not affect the direction.
module pinhole_camera_ray_generator import prg_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_idx,
	input  logic [CFG_W-1:0]        cfg_wdata,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [XY_W-1:0]         pixel_x,
	input  logic [XY_W-1:0]         pixel_y,
	input  logic                    jitter_enable,
	input  logic [JIT_W-1:0]        jitter_u,
	input  logic [JIT_W-1:0]        jitter_v,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [DIR_W-1:0] dir_x,
	output logic signed [DIR_W-1:0] dir_y,
	output logic signed [DIR_W-1:0] dir_z
);

	cam_cfg_t         cfg_q;
	logic             en;
	logic             d_vld, s_vld, q_vld;
	dvec_t            dvec;
	logic [SUM_W-1:0] sum;
	nrm_t             nrm_a, nrm_b;
	logic [LEN_W-1:0] len;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fwd   <= RST_FWD;
			cfg_q.right <= RST_RIGHT;
			cfg_q.up    <= RST_UP;
			cfg_q.ratio <= RST_RATIO;
			cfg_q.inv_w <= RST_INV;
			cfg_q.inv_h <= RST_INV;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_CAM_POS: begin
					// origin does not enter the direction
				end
				REG_FWD:   cfg_q.fwd   <= cfg_wdata;
				REG_RIGHT: cfg_q.right <= cfg_wdata;
				REG_UP:    cfg_q.up    <= cfg_wdata;
				REG_RATIO: cfg_q.ratio <= cfg_wdata[RATIO_W-1:0];
				REG_INV_W: cfg_q.inv_w <= cfg_wdata[INV_W-1:0];
				REG_INV_H: cfg_q.inv_h <= cfg_wdata[INV_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// pipeline advances unless a result waits untaken
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	prg_setup u_setup (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (in_valid),
		.px      (pixel_x),
		.py      (pixel_y),
		.jit     (jitter_enable),
		.ju      (jitter_u),
		.jv      (jitter_v),
		.cfg     (cfg_q),
		.out_vld (d_vld),
		.d       (dvec)
	);

	prg_norm u_norm (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (d_vld),
		.d       (dvec),
		.out_vld (s_vld),
		.sum     (sum),
		.nrm     (nrm_a)
	);

	prg_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (s_vld),
		.sum     (sum),
		.nrm_i   (nrm_a),
		.out_vld (q_vld),
		.len     (len),
		.nrm_o   (nrm_b)
	);

	prg_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (q_vld),
		.len     (len),
		.nrm     (nrm_b),
		.out_vld (out_valid),
		.dir_x   (dir_x),
		.dir_y   (dir_y),
		.dir_z   (dir_z)
	);

	// a waiting result blocks new items
	a_stall_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("item accepted while output stalled");

	// unit vector components stay within one
	a_dir_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> dir_x >= -DIR_W'(DIR_ONE) && dir_x <= DIR_W'(DIR_ONE)
		           && dir_y >= -DIR_W'(DIR_ONE) && dir_y <= DIR_W'(DIR_ONE)
		           && dir_z >= -DIR_W'(DIR_ONE) && dir_z <= DIR_W'(DIR_ONE))
		else $error("ray direction component out of range");

	// a new result shows up only on an advancing cycle
	a_out_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_ready))
		else $error("result appeared while pipeline held");

endmodule
